/* sv/weighted_mean_and_square_accumulator_assert.svh */
// Assertion macros shared by the checker of the weighted mean and square accumulator.
// Depends on nothing; the checker includes this file by its bare name.
`ifndef WEIGHTED_MEAN_AND_SQUARE_ACCUMULATOR_ASSERT_SVH
`define WEIGHTED_MEAN_AND_SQUARE_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define WMSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define WMSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays active during reset.
`define WMSA_ASSERT_NXT_RAW(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/wmsa_pkg.sv */
// Shared types and constants of the weighted mean and square accumulator.
// Used by the top level, the divider and the checker; depends on nothing.
package wmsa_pkg;

    localparam int ACT_W  = 2;
    localparam int DIM_W  = 3;
    localparam int VAL_W  = 32;
    localparam int WT_W   = 32;
    localparam int SQ_W   = 64;
    localparam int TW_W   = 40;
    localparam int SUM_W  = 41;
    localparam int ACC_W  = 105;
    localparam int STEP_W = 7;

    // Number of coordinates that the index field can address.
    localparam int DIM_SPAN = 2 ** DIM_W;

    localparam int DIV_SHORT = 32;
    localparam int DIV_LONG  = 64;

    // Stream packing.
    localparam int S_TDATA_W  = 72;
    localparam int S_VAL_LSB  = 3;
    localparam int S_WT_LSB   = 35;
    localparam int M_TDATA_W  = 104;
    localparam int M_MEAN_LSB = 3;
    localparam int M_SQ_LSB   = 35;
    localparam int M_SZ_BIT   = 99;
    localparam int M_ANY_BIT  = 100;

    localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ATTACH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SET    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

    // Request to the shared divider: a start pulse and the run length select.
    typedef struct packed {
        logic start;
        logic wide;
    } t_div_req;

endpackage

/* sv/wmsa_div.sv */
// Restoring divider, one quotient bit per cycle, shared by both weighted divisions.
// Depends on wmsa_pkg.
module wmsa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wmsa_pkg::t_div_req         i_req,
    input  logic [wmsa_pkg::SUM_W-1:0] i_num_hi,
    input  logic [wmsa_pkg::SQ_W-1:0]  i_num_lo,
    input  logic [wmsa_pkg::SUM_W-1:0] i_den,
    output logic [wmsa_pkg::SQ_W-1:0]  o_quot,
    output logic                       o_done
);
    import wmsa_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_rem;
    logic [SQ_W-1:0]   r_q;
    logic [SUM_W-1:0]  r_den;

    logic [SUM_W:0] trial;
    logic [SUM_W:0] diff;
    logic           ge;

    // The remainder stays below the divisor, so the shifted trial fits one extra bit.
    assign trial = {r_rem, r_q[SQ_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= i_req.wide ? STEP_W'(DIV_LONG) : STEP_W'(DIV_SHORT);
            end else if (r_busy) begin
                r_cnt  <= r_cnt - STEP_W'(1);
                r_done <= (r_cnt == STEP_W'(1));
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_num_hi;
            r_q   <= i_num_lo;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            r_q   <= {r_q[SQ_W-2:0], ge};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

/* sv/weighted_mean_and_square_accumulator.sv */
// Weighted running mean and mean of squares over up to eight coordinates.
// Depends on wmsa_pkg and instantiates the shared divider wmsa_div.
//
// Usage. Each input transfer on the s_axis channel carries one coordinate of a
// point: the action in tuser, the coordinate index, value and point weight in
// tdata, and tlast on the final coordinate of the point. Every input transfer
// produces exactly one result transfer on the m_axis channel, in order, with the
// updated mean and mean of squares of that coordinate and its status flags.
// Load and set replace a coordinate by the sample; attach blends the sample into
// the stored values with the old total weight, which is committed on tlast.
// Timing. One item is in work at a time and s_axis_tready is low meanwhile. An
// attach item keeps the block busy until its result enters the output register:
// eleven products run through one shared 32x32 multiplier, each but the final
// square in a multiply step and an add step, and the mean (32 quotient bits) and
// the mean of squares (64 quotient bits) share one restoring divider at one bit
// per cycle. Load and set run only the sample square and the final square; an
// unused action and a zero-weight attach run only the final square.
// Reset clears the stores, the total weight and the flag history.
// A stalled receiver holds the result in the output register; the next item is
// still taken and waits at its final step until the output register is free.
module weighted_mean_and_square_accumulator #(
    parameter int DIMS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // dim_index [2:0], sample_value [34:3], sample_weight [66:35], zeros above
    input  logic [wmsa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action [1:0]
    input  logic [wmsa_pkg::ACT_W-1:0]     s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_dim [2:0], mean_value [34:3], mean_square [98:35], sigma_zero [99],
    // any_sigma_zero [100], zeros above
    output logic [wmsa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // zero_weight [0]
    output logic [0:0]                     m_axis_tuser,
    output logic                           m_axis_tlast
);
    import wmsa_pkg::*;

    // Only indexes that the coordinate field can reach need storage.
    localparam int DEPTH = (DIMS < DIM_SPAN) ? DIMS : DIM_SPAN;
    localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_ADD    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DWAIT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // Sequencer steps, one product each.
    localparam logic [3:0] U_SQX = 4'd0;   // square of the sample
    localparam logic [3:0] U_M0  = 4'd1;   // biased mean times low weight word
    localparam logic [3:0] U_M1  = 4'd2;   // biased mean times high weight byte
    localparam logic [3:0] U_M2  = 4'd3;   // biased sample times its weight
    localparam logic [3:0] U_S0  = 4'd4;   // square store low word times low weight
    localparam logic [3:0] U_S1  = 4'd5;
    localparam logic [3:0] U_S2  = 4'd6;
    localparam logic [3:0] U_S3  = 4'd7;
    localparam logic [3:0] U_S4  = 4'd8;   // sample square times sample weight
    localparam logic [3:0] U_S5  = 4'd9;
    localparam logic [3:0] U_SQM = 4'd10;  // square of the final mean

    localparam logic [VAL_W-1:0] OFS = {1'b1, {(VAL_W-1){1'b0}}};

    function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
        mag32 = v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
    endfunction

    // Control and state.
    logic [2:0]       r_state;
    logic [3:0]       r_u;
    logic             r_out_valid;
    logic [TW_W-1:0]  r_tw;
    logic             r_seen;
    logic [VAL_W-1:0] r_mean_store [DEPTH];
    logic [SQ_W-1:0]  r_square_store [DEPTH];

    // Item in work.
    logic [ACT_W-1:0] r_act;
    logic [DIM_W-1:0] r_dim;
    logic [IDXW-1:0]  r_idx;
    logic             r_ok;
    logic             r_last;
    logic             r_zw;
    logic [VAL_W-1:0] r_x;
    logic [WT_W-1:0]  r_w;
    logic [SUM_W-1:0] r_sum;
    logic [VAL_W-1:0] r_m;
    logic [SQ_W-1:0]  r_s;
    logic [SQ_W-1:0]  r_sqx;
    logic [SQ_W-1:0]  r_prod;
    logic [ACC_W-1:0] r_acc;

    // Output register.
    logic [DIM_W-1:0] r_o_dim;
    logic [VAL_W-1:0] r_o_mean;
    logic [SQ_W-1:0]  r_o_sq;
    logic             r_o_sz;
    logic             r_o_any;
    logic             r_o_zw;
    logic             r_o_last;

    logic [DIM_W-1:0] in_dim;
    logic [VAL_W-1:0] in_val;
    logic [WT_W-1:0]  in_wt;
    logic             in_ok;
    logic [IDXW-1:0]  in_idx;
    logic [SUM_W-1:0] in_sum;
    logic             in_zero;
    logic             in_fire;

    logic [VAL_W-1:0] op_a;
    logic [VAL_W-1:0] op_b;
    logic [SQ_W-1:0]  mul_out;
    logic [ACC_W-1:0] p0;
    logic [ACC_W-1:0] p32;
    logic [ACC_W-1:0] p64;
    logic [ACC_W-1:0] n_acc;

    t_div_req         div_req;
    logic [SUM_W-1:0] div_hi;
    logic [SQ_W-1:0]  div_lo;
    logic [SQ_W-1:0]  div_q;
    logic             div_done;

    logic             done_fire;
    logic             sz;
    logic             seen;
    logic             any_out;
    logic             wr_store;

    assign in_dim  = s_axis_tdata[DIM_W-1:0];
    assign in_val  = s_axis_tdata[S_VAL_LSB +: VAL_W];
    assign in_wt   = s_axis_tdata[S_WT_LSB +: WT_W];
    assign in_ok   = (32'(in_dim) < DIMS);
    assign in_idx  = in_dim[IDXW-1:0];
    assign in_sum  = {1'b0, r_tw} + {{(SUM_W-WT_W){1'b0}}, in_wt};
    assign in_zero = (in_sum == '0);

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Operand selection for the shared multiplier. Adding the offset to a
    // signed Q16.16 value only flips its top bit.
    always_comb begin
        case (r_u)
            U_SQX: begin
                op_a = mag32(r_x);
                op_b = mag32(r_x);
            end
            U_M0: begin
                op_a = r_m ^ OFS;
                op_b = r_tw[VAL_W-1:0];
            end
            U_M1: begin
                op_a = r_m ^ OFS;
                op_b = {{(2*VAL_W-TW_W){1'b0}}, r_tw[TW_W-1:VAL_W]};
            end
            U_M2: begin
                op_a = r_x ^ OFS;
                op_b = r_w;
            end
            U_S0: begin
                op_a = r_s[VAL_W-1:0];
                op_b = r_tw[VAL_W-1:0];
            end
            U_S1: begin
                op_a = r_s[VAL_W-1:0];
                op_b = {{(2*VAL_W-TW_W){1'b0}}, r_tw[TW_W-1:VAL_W]};
            end
            U_S2: begin
                op_a = r_s[SQ_W-1:VAL_W];
                op_b = r_tw[VAL_W-1:0];
            end
            U_S3: begin
                op_a = r_s[SQ_W-1:VAL_W];
                op_b = {{(2*VAL_W-TW_W){1'b0}}, r_tw[TW_W-1:VAL_W]};
            end
            U_S4: begin
                op_a = r_sqx[VAL_W-1:0];
                op_b = r_w;
            end
            U_S5: begin
                op_a = r_sqx[SQ_W-1:VAL_W];
                op_b = r_w;
            end
            U_SQM: begin
                op_a = mag32(r_m);
                op_b = mag32(r_m);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_out = {{VAL_W{1'b0}}, op_a} * {{VAL_W{1'b0}}, op_b};

    // Partial products are placed at word offsets into the numerator accumulator.
    assign p0  = {{(ACC_W-SQ_W){1'b0}}, r_prod};
    assign p32 = {{(ACC_W-SQ_W-VAL_W){1'b0}}, r_prod, {VAL_W{1'b0}}};
    assign p64 = {r_prod[ACC_W-SQ_W-1:0], {SQ_W{1'b0}}};

    always_comb begin
        case (r_u)
            U_M0, U_S0:             n_acc = p0;
            U_M1, U_S1, U_S2, U_S5: n_acc = r_acc + p32;
            U_M2, U_S4:             n_acc = r_acc + p0;
            U_S3:                   n_acc = r_acc + p64;
            default:                n_acc = r_acc;
        endcase
    end

    // After the mean products the step counter rests on U_S0; after the square
    // products it rests on U_SQM, which selects the long division.
    assign div_req.start = (r_state == S_DSTART);
    assign div_req.wide  = (r_u == U_SQM);
    assign div_hi = div_req.wide ? r_acc[ACC_W-1:SQ_W] : r_acc[VAL_W +: SUM_W];
    assign div_lo = div_req.wide ? r_acc[SQ_W-1:0] : {r_acc[VAL_W-1:0], {VAL_W{1'b0}}};

    wmsa_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (div_req),
        .i_num_hi (div_hi),
        .i_num_lo (div_lo),
        .i_den    (r_sum),
        .o_quot   (div_q),
        .o_done   (div_done)
    );

    // Final step: the square of the final mean sits in r_prod.
    assign done_fire = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    assign sz        = (r_s == r_prod);
    assign seen      = r_seen || sz;
    assign any_out   = (r_act != ACT_NONE) && r_last && seen;
    assign wr_store  = r_ok && ((r_act == ACT_LOAD) || (r_act == ACT_SET) ||
                                ((r_act == ACT_ATTACH) && !r_zw));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_u         <= U_SQX;
            r_out_valid <= 1'b0;
            r_tw        <= '0;
            r_seen      <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                r_mean_store[i]   <= '0;
                r_square_store[i] <= '0;
            end
        end else begin
            // A new result may replace the one leaving in the same cycle.
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        // An unused action or an attach with a zero total weight keeps the stored
                        // values and only needs the variance check.
                        if ((s_axis_tuser == ACT_NONE) ||
                            ((s_axis_tuser == ACT_ATTACH) && in_zero)) begin
                            r_u <= U_SQM;
                        end else begin
                            r_u <= U_SQX;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= (r_u == U_SQM) ? S_DONE : S_ADD;
                end
                S_ADD: begin
                    case (r_u)
                        U_SQX: begin
                            r_u     <= (r_act == ACT_ATTACH) ? U_M0 : U_SQM;
                            r_state <= S_MUL;
                        end
                        U_M2, U_S5: begin
                            r_u     <= r_u + 4'd1;
                            r_state <= S_DSTART;
                        end
                        default: begin
                            r_u     <= r_u + 4'd1;
                            r_state <= S_MUL;
                        end
                    endcase
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (done_fire) begin
                        r_state     <= S_IDLE;
                        if (r_act != ACT_NONE) begin
                            r_seen <= r_last ? 1'b0 : seen;
                        end
                        // The total weight moves only on the last coordinate, so
                        // every coordinate of a point blends with the same weight.
                        if (r_last && (r_act == ACT_LOAD)) begin
                            r_tw <= {{(TW_W-WT_W){1'b0}}, r_w};
                        end
                        if (r_last && (r_act == ACT_ATTACH) && !r_zw) begin
                            r_tw <= r_sum[SUM_W-1] ? {TW_W{1'b1}} : r_sum[TW_W-1:0];
                        end
                        if (wr_store) begin
                            r_mean_store[r_idx]   <= r_m;
                            r_square_store[r_idx] <= r_s;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act  <= s_axis_tuser;
            r_dim  <= in_dim;
            r_idx  <= in_idx;
            r_ok   <= in_ok;
            r_last <= s_axis_tlast;
            r_zw   <= (s_axis_tuser == ACT_ATTACH) && in_zero;
            r_x    <= in_val;
            r_w    <= in_wt;
            r_sum  <= in_sum;
            // A coordinate without storage reads as zero.
            r_m    <= in_ok ? r_mean_store[in_idx] : '0;
            r_s    <= in_ok ? r_square_store[in_idx] : '0;
        end
        if (r_state == S_MUL) begin
            r_prod <= mul_out;
        end
        if (r_state == S_ADD) begin
            if (r_u == U_SQX) begin
                r_sqx <= r_prod;
                if (r_act != ACT_ATTACH) begin
                    r_m <= r_x;
                    r_s <= r_prod;
                end
            end else begin
                r_acc <= n_acc;
            end
        end
        if ((r_state == S_DWAIT) && div_done) begin
            if (r_u == U_SQM) begin
                r_s <= div_q;
            end else begin
                // Remove the offset that kept the mean numerator unsigned.
                r_m <= div_q[VAL_W-1:0] ^ OFS;
            end
        end
        if (done_fire) begin
            r_o_dim  <= r_dim;
            r_o_mean <= r_m;
            r_o_sq   <= r_s;
            r_o_sz   <= sz;
            r_o_any  <= any_out;
            r_o_zw   <= r_zw;
            r_o_last <= r_last;
        end
    end

    assign m_axis_tvalid = i_rst_n && r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-M_ANY_BIT-1){1'b0}}, r_o_any, r_o_sz,
                            r_o_sq, r_o_mean, r_o_dim};
    assign m_axis_tuser  = r_o_zw;
    assign m_axis_tlast  = r_o_last;

endmodule

/* sv/wmsa_checker.sv */
// Port-level checker of the weighted mean and square accumulator, bound to the top.
// Depends on wmsa_pkg and the assertion macros header.
`include "weighted_mean_and_square_accumulator_assert.svh"

module wmsa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [wmsa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic [wmsa_pkg::ACT_W-1:0]     s_axis_tuser,
    input logic                           s_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [wmsa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [0:0]                     m_axis_tuser,
    input logic                           m_axis_tlast
);
    import wmsa_pkg::*;

    // A stalled result keeps its contents until the transfer.
    `WMSA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast),
        "stalled result changed")

    // One item at a time: an input transfer closes the input side.
    `WMSA_ASSERT_NXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "input taken while an item is in work")

    // The point-wide variance flag only appears on a last coordinate.
    `WMSA_ASSERT_IMP(a_any_on_last, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast,
        !m_axis_tdata[M_ANY_BIT], "point-wide flag on an inner coordinate")

    // Reset empties the output register.
    `WMSA_ASSERT_NXT_RAW(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid,
        "result pending after reset")

endmodule

bind weighted_mean_and_square_accumulator wmsa_checker u_wmsa_checker (.*);

/* tb/wmsa_moments_checker.sv */
// Scoreboard for the weighted mean and square accumulator: it predicts each result
// from the accepted input transfers and compares every output transfer in order.
// Depends on wmsa_pkg for the stream packing, the field widths and the action codes.
module wmsa_moments_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    // dim_index, sample_value, sample_weight from the lowest bit up
    input  logic [wmsa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action
    input  logic [wmsa_pkg::ACT_W-1:0]     s_axis_tuser,
    input  logic                           s_axis_tlast,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_dim, mean_value, mean_square, sigma_zero, any_sigma_zero from the lowest bit up
    input  logic [wmsa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // zero_weight
    input  logic [0:0]                     m_axis_tuser,
    input  logic                           m_axis_tlast,
    output int                             o_mismatches,
    output int                             o_pending
);
    import wmsa_pkg::*;

    // Adding 2^31 modulo 2^32 turns a signed mean into an offset one.
    localparam logic [VAL_W-1:0] SIGN_FLIP  = 32'h8000_0000;
    localparam logic [TW_W-1:0]  WEIGHT_CAP = '1;

    typedef struct packed {
        logic [DIM_W-1:0] dim;
        logic [VAL_W-1:0] mean;
        logic [SQ_W-1:0]  msq;
        logic             sz;
        logic             any_sz;
        logic             zw;
        logic             last;
    } moments_t;

    logic [TW_W-1:0]  weight_sum;
    logic [VAL_W-1:0] means   [DIM_SPAN];
    logic [SQ_W-1:0]  squares [DIM_SPAN];
    logic             sz_seen;
    moments_t         moments_due [$];
    int               mismatch_count = 0;
    int               pending_count  = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    // Exact square of a signed Q16.16 value, read as Q32.32.
    function automatic logic [SQ_W-1:0] square_of(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] mag;
        mag = v[VAL_W-1] ? (~v + 32'd1) : v;
        return 64'(mag) * 64'(mag);
    endfunction

    // floor((wa*a + wb*b) / total), clamped to 64 bits.
    function automatic logic [SQ_W-1:0] blend_floor(input logic [SQ_W-1:0] a,
            input logic [TW_W-1:0] wa, input logic [SQ_W-1:0] b, input logic [WT_W-1:0] wb,
            input logic [SUM_W-1:0] total);
        logic [127:0] quo;
        quo = (128'(a) * 128'(wa) + 128'(b) * 128'(wb)) / 128'(total);
        return (quo[127:64] != '0) ? '1 : quo[63:0];
    endfunction

    // Applies one sample to the mirrored state and returns the result it causes.
    function automatic moments_t step_moments(input logic [ACT_W-1:0] act,
            input logic [DIM_W-1:0] dim, input logic [VAL_W-1:0] x,
            input logic [WT_W-1:0] w, input logic last);
        moments_t         r;
        logic [SUM_W-1:0] total;
        logic [SQ_W-1:0]  blended;
        logic             seen;
        r.dim    = dim;
        r.mean   = means[dim];
        r.msq    = squares[dim];
        r.any_sz = 1'b0;
        r.zw     = 1'b0;
        r.last   = last;
        total    = SUM_W'(weight_sum) + SUM_W'(w);
        case (act)
            ACT_LOAD, ACT_SET: begin
                r.mean = x;
                r.msq  = square_of(x);
                if (act == ACT_LOAD && last)
                    weight_sum = TW_W'(w);
            end
            ACT_ATTACH: begin
                if (total == '0) begin
                    r.zw = 1'b1;
                end else begin
                    // Both blends use the weight from before this point.
                    blended = blend_floor(64'(r.mean ^ SIGN_FLIP), weight_sum,
                                          64'(x ^ SIGN_FLIP), w, total);
                    r.mean  = blended[VAL_W-1:0] ^ SIGN_FLIP;
                    r.msq   = blend_floor(r.msq, weight_sum, square_of(x), w, total);
                    if (last)
                        weight_sum = (total > SUM_W'(WEIGHT_CAP)) ? WEIGHT_CAP
                                                                  : total[TW_W-1:0];
                end
            end
            default: ;
        endcase
        if (act != ACT_NONE && !r.zw) begin
            means[dim]   = r.mean;
            squares[dim] = r.msq;
        end
        r.sz = (r.msq == square_of(r.mean));
        // The unused action leaves the flag history alone.
        if (act != ACT_NONE) begin
            seen = sz_seen | r.sz;
            if (last) begin
                r.any_sz = seen;
                sz_seen  = 1'b0;
            end else begin
                sz_seen = seen;
            end
        end
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [SQ_W-1:0] want,
                              input logic [SQ_W-1:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        moments_t want;
        moments_t got;
        if (!i_rst_n) begin
            weight_sum = '0;
            sz_seen    = 1'b0;
            for (int i = 0; i < DIM_SPAN; i++) begin
                means[i]   = '0;
                squares[i] = '0;
            end
            moments_due.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                moments_due.push_back(step_moments(s_axis_tuser,
                                                   s_axis_tdata[S_VAL_LSB-1:0],
                                                   s_axis_tdata[S_VAL_LSB +: VAL_W],
                                                   s_axis_tdata[S_WT_LSB +: WT_W],
                                                   s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready) begin
                got.dim    = m_axis_tdata[M_MEAN_LSB-1:0];
                got.mean   = m_axis_tdata[M_MEAN_LSB +: VAL_W];
                got.msq    = m_axis_tdata[M_SQ_LSB +: SQ_W];
                got.sz     = m_axis_tdata[M_SZ_BIT];
                got.any_sz = m_axis_tdata[M_ANY_BIT];
                got.zw     = m_axis_tuser[0];
                got.last   = m_axis_tlast;
                if (moments_due.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, actual 0x%0h",
                             $time, got);
                    mismatch_count++;
                end else begin
                    want = moments_due.pop_front();
                    if (got.dim != want.dim)       flag_field("out_dim", want.dim, got.dim);
                    if (got.mean != want.mean)     flag_field("mean_value", want.mean, got.mean);
                    if (got.msq != want.msq)       flag_field("mean_square", want.msq, got.msq);
                    if (got.sz != want.sz)         flag_field("sigma_zero", want.sz, got.sz);
                    if (got.any_sz != want.any_sz) flag_field("any_sigma_zero", want.any_sz,
                                                              got.any_sz);
                    if (got.zw != want.zw)         flag_field("zero_weight", want.zw, got.zw);
                    if (got.last != want.last)     flag_field("out_last", want.last, got.last);
                end
            end
        end
        pending_count = moments_due.size();
    end

endmodule

/* tb/testbench.sv */
// Top of the testbench for the weighted mean and square accumulator: clock, reset,
// stimulus, receiver back-pressure, a watchdog and the final verdict.
// Depends on wmsa_pkg, the block itself and the scoreboard wmsa_moments_checker.
module testbench;
    import wmsa_pkg::*;

    // Items counted toward the random part include the weight saturation run.
    localparam int RANDOM_ITEMS    = 830;
    localparam int SAT_AT          = 200;
    localparam int SAT_RUN         = 270;
    localparam int DRAIN_AT        = 550;
    localparam int BIG_HOLD_AT     = 150;
    localparam int BIG_HOLD_CYCLES = 1500;
    // The limit has to cover an attach item plus the long receiver hold, with nothing moving.
    localparam int IDLE_LIMIT      = 20000;
    localparam int TAIL_CYCLES     = 20;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // dim_index [2:0], sample_value [34:3], sample_weight [66:35], zeros above
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    // action [1:0]
    logic [ACT_W-1:0]       s_axis_tuser  = ACT_LOAD;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // out_dim [2:0], mean_value [34:3], mean_square [98:35], sigma_zero [99],
    // any_sigma_zero [100], zeros above
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    // zero_weight [0]
    logic [0:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    int                     mismatches;
    int                     pending;

    int                     sent_count    = 0;
    int                     counted_items = 0;
    bit                     calm          = 1'b0;
    logic [VAL_W-1:0]       last_sent [DIM_SPAN] = '{default: '0};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    weighted_mean_and_square_accumulator #(.DIMS(DIM_SPAN)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    wmsa_moments_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // Gap before the next input transfer: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Coordinate values: the range limits, small values of both signs, anything.
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return {{12{v[19]}}, v[19:0]};
            default: return v;
        endcase
    endfunction

    // Weights: zero, the maximum, a few units of Q16.16, anything.
    function automatic logic [WT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom_range(1, 32'h0003_0000);
            default: return $urandom();
        endcase
    endfunction

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Offers one sample after a random gap and returns at the edge of its transfer.
    // Valid stays high afterwards so that back-to-back items need no extra edge.
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [DIM_W-1:0] dim,
                             input logic [VAL_W-1:0] x, input logic [WT_W-1:0] w,
                             input logic last);
        pause_sender(pick_gap());
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= S_TDATA_W'({w, x, dim});
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_count++;
        if (act != ACT_NONE) begin
            counted_items++;
            last_sent[dim] = x;
        end
    endtask

    // One point over consecutive coordinates with a common action and weight. A point
    // sent without its closing coordinate leaves the weight and the flag history open.
    task automatic random_point(input bit finish);
        int               n;
        int               base;
        int               r;
        bit               reuse;
        logic [ACT_W-1:0] act;
        logic [WT_W-1:0]  w;
        logic [DIM_W-1:0] dim;
        n     = $urandom_range(1, DIM_SPAN);
        base  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, DIM_SPAN - 1) : 0;
        r     = $urandom_range(0, 99);
        act   = (r < 20) ? ACT_LOAD : (r < 85) ? ACT_ATTACH : ACT_SET;
        w     = pick_weight();
        // Sending a coordinate again tends to keep the variance at zero.
        reuse = ($urandom_range(0, 5) == 0);
        for (int k = 0; k < n; k++) begin
            dim = DIM_W'(base + k);
            send_item(act, dim, reuse ? last_sent[dim] : pick_value(), w,
                      finish && (k == n - 1));
        end
    endtask

    // Receiver: short random stalls, calm stretches, and one long hold-off that lets
    // the block fill up and stall its input while the sender keeps offering.
    int unsigned hold_left    = 0;
    int unsigned calm_left    = 0;
    bit          big_hold_done = 1'b0;

    always @(posedge i_clk) begin
        int r;
        if (!big_hold_done && sent_count >= BIG_HOLD_AT) begin
            big_hold_done = 1'b1;
            hold_left     = BIG_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (calm_left != 0) begin
            calm_left--;
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b1;
            r = $urandom_range(0, 99);
            if (r < 3)
                calm_left = $urandom_range(100, 400);
            else if (r < 20)
                hold_left = $urandom_range(1, 3);
            else if (r < 23)
                hold_left = $urandom_range(20, 120);
        end
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        logic [VAL_W-1:0] x;
        int               kind;
        bit               sat_done;
        bit               drain_done;
        sat_done   = 1'b0;
        drain_done = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Attach straight after reset: the total weight is zero, nothing changes.
        send_item(ACT_ATTACH, 3'd0, 32'h0001_0000, 32'd0, 1'b1);
        // The unused action only reports what is stored.
        send_item(ACT_NONE, 3'd5, 32'hDEAD_BEEF, 32'h1234_5678, 1'b0);
        // Load a full point at the range limits with the largest weight.
        for (int k = 0; k < DIM_SPAN; k++) begin
            case (k)
                0:       x = 32'h8000_0000;
                1:       x = 32'h7FFF_FFFF;
                2:       x = 32'h0000_0000;
                3:       x = 32'hFFFF_FFFF;
                4:       x = 32'h0000_0001;
                5:       x = 32'h0001_0000;
                6:       x = 32'hFFFF_0000;
                default: x = 32'h1234_5678;
            endcase
            send_item(ACT_LOAD, DIM_W'(k), x, '1, k == DIM_SPAN - 1);
        end
        // Attach the opposite extremes with the largest weight.
        send_item(ACT_ATTACH, 3'd0, 32'h7FFF_FFFF, '1, 1'b0);
        send_item(ACT_ATTACH, 3'd1, 32'h8000_0000, '1, 1'b0);
        send_item(ACT_ATTACH, 3'd2, 32'hFFFF_FFFF, '1, 1'b0);
        send_item(ACT_ATTACH, 3'd3, 32'h0000_0000, '1, 1'b1);
        // Set keeps the weight; a zero-weight attach against a nonzero total.
        send_item(ACT_SET, 3'd2, 32'hFFFF_FFFF, 32'd0, 1'b1);
        send_item(ACT_ATTACH, 3'd4, 32'h0000_0001, 32'd0, 1'b1);
        // Loading with zero weight empties the total, so the next attaches report it.
        send_item(ACT_LOAD, 3'd6, 32'h0002_8000, 32'd0, 1'b1);
        send_item(ACT_ATTACH, 3'd6, 32'h7FFF_FFFF, 32'd0, 1'b0);
        send_item(ACT_ATTACH, 3'd7, 32'h8000_0000, 32'd0, 1'b1);
        // From an empty total the smallest weight makes the mean the sample itself.
        send_item(ACT_ATTACH, 3'd1, 32'h8000_0000, 32'd1, 1'b1);
        send_item(ACT_NONE, 3'd7, 32'd0, 32'd0, 1'b1);

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            if (!sat_done && counted_items >= SAT_AT) begin
                // Single-coordinate points at the largest weight drive the total
                // weight into saturation and keep attaching there.
                sat_done = 1'b1;
                calm     = 1'b0;
                send_item(ACT_LOAD, DIM_W'($urandom_range(0, DIM_SPAN - 1)), pick_value(),
                          '1, 1'b1);
                for (int k = 0; k < SAT_RUN; k++)
                    send_item(ACT_ATTACH, DIM_W'($urandom_range(0, DIM_SPAN - 1)),
                              pick_value(), '1, 1'b1);
            end
            if (!drain_done && counted_items >= DRAIN_AT) begin
                // Let every result come out before offering anything more.
                drain_done = 1'b1;
                pause_sender(1);
                while (pending != 0) @(posedge i_clk);
            end
            calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 72)
                random_point(1'b1);
            else if (kind < 84)
                random_point(1'b0);
            else
                send_item(ACT_W'($urandom_range(0, 3)), DIM_W'($urandom_range(0, 7)),
                          $urandom(), pick_weight(), 1'($urandom_range(0, 1)));
        end

        pause_sender(1);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
